// File: sv/fit_policy_hole_allocator_core_macros.svh
// ---------------------------------------------------------------------------
// fit policy hole allocator assertion macros
// concurrent check wrappers clocked on clk_i, off while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef FIT_POLICY_HOLE_ALLOCATOR_CORE_MACROS_SVH
`define FIT_POLICY_HOLE_ALLOCATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FPHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FPHA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`else

`define FPHA_ASSERT_IMP(label, ante, cons, msg)
`define FPHA_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// File: sv/fpha_pkg.sv
// ---------------------------------------------------------------------------
// fpha_pkg
// shared constants and types of the fit policy hole allocator
// ---------------------------------------------------------------------------
package fpha_pkg;

  localparam int MAX_HOLES_DEF = 16;
  localparam int SIZE_BITS_DEF = 16;

  localparam logic [19:0] SUM_MAX = 20'hFFFFF;

  // request modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  // fit policies, code 3 falls back to first fit
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // register indexes (word address)
  localparam logic REG_FIT_POLICY = 1'b0;
  localparam logic REG_NUM_HOLES  = 1'b1;

  localparam logic [4:0] NUM_HOLES_RST = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } fpha_state_e;

endpackage

// File: sv/fit_policy_hole_allocator_core.sv
// ---------------------------------------------------------------------------
// fit_policy_hole_allocator_core
// hole table with first, best and worst fit allocation and free space sum
// ---------------------------------------------------------------------------
// A request is taken when start is high while busy is low. A load request
// (mode 0) writes one hole size; an allocate request (mode 1) picks a hole
// by the fit policy register, takes the size from it and reports the hole.
// Every request gives exactly one result, shown for a single cycle with
// done_o high; the receiver cannot stall, so it must catch it then. A request
// keeps busy high until its result is shown, since the hole table sits in one
// memory with a single read port and every request walks the holes in use,
// n = min(num_holes, MAX_HOLES), one per cycle to pick the hole and to form
// the free space total, then does write-back and result in ST_FINISH. The
// table needs no clearing pass: a valid bit per hole, cleared by reset, makes
// a never written hole read as zero.
// Registers (APB, pready always high): 0x0 fit_policy, 0x4 num_holes.
// ---------------------------------------------------------------------------
`include "fit_policy_hole_allocator_core_macros.svh"

module fit_policy_hole_allocator_core
  import fpha_pkg::*;
#(
  parameter int MAX_HOLES = MAX_HOLES_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [3:0]  hole_slot_i,
  input  logic [15:0] size_value_i,
  // result channel
  output logic        done_o,
  output logic        granted_o,
  output logic [3:0]  chosen_hole_o,
  output logic [15:0] hole_remaining_o,
  output logic [19:0] total_free_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W  = $clog2(MAX_HOLES);
  localparam int CNT_W  = ($clog2(MAX_HOLES + 1) > 5) ? $clog2(MAX_HOLES + 1) : 5;
  localparam int CMP_W  = (SIZE_BITS > 16) ? SIZE_BITS : 16;
  localparam int TSUM_RAW = SIZE_BITS + $clog2(MAX_HOLES) + 1;
  localparam int TSUM_W = (TSUM_RAW > 21) ? TSUM_RAW : 21;

  // configuration registers
  logic [1:0] fit_policy_q;
  logic [4:0] num_holes_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q <= POL_FIRST;
      num_holes_q  <= NUM_HOLES_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FIT_POLICY: fit_policy_q <= pwdata[1:0];
        REG_NUM_HOLES:  num_holes_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FIT_POLICY: prdata = {30'd0, fit_policy_q};
      REG_NUM_HOLES:  prdata = {27'd0, num_holes_q};
      default:        prdata = '0;
    endcase
  end

  // holes in use, saturated to the table depth
  logic [CNT_W-1:0] n_use;
  assign n_use = (CNT_W'(num_holes_q) > CNT_W'(MAX_HOLES)) ? CNT_W'(MAX_HOLES)
                                                            : CNT_W'(num_holes_q);

  // control and request registers
  fpha_state_e      state_q, state_d;
  logic             mode_q;
  logic [3:0]       slot_q;
  logic [15:0]      req_q;
  logic             slot_ok_q;
  logic [CNT_W-1:0] rd_addr_q;
  logic             pend_q;
  logic [IDX_W-1:0] pend_idx_q;

  // scan results
  logic              found_q;
  logic [IDX_W-1:0]  pos_q;
  logic [SIZE_BITS-1:0] best_q;
  logic [TSUM_W-1:0] sum_q;

  // result registers
  logic        done_q;
  logic        granted_q;
  logic [3:0]  chosen_q;
  logic [15:0] remain_q;
  logic [19:0] total_q;

  logic [MAX_HOLES-1:0] valid_q;

  logic accept;
  logic issuing;
  logic slot_ok;

  assign accept  = (state_q == ST_IDLE) && start;
  assign issuing = (state_q == ST_SCAN) && (rd_addr_q < n_use);
  assign slot_ok = (32'(hole_slot_i) < MAX_HOLES);

  // result of the finishing cycle
  logic                 alloc_hit;
  logic                 load_ok;
  logic [SIZE_BITS-1:0] new_val;
  logic [SIZE_BITS-1:0] load_val;
  logic [TSUM_W-1:0]    total_true;
  logic [19:0]          total_sat;

  assign alloc_hit  = (mode_q == MODE_ALLOC) && found_q;
  assign load_ok    = (mode_q == MODE_LOAD) && slot_ok_q;
  assign new_val    = best_q - SIZE_BITS'(req_q);
  assign load_val   = SIZE_BITS'(req_q);
  assign total_true = alloc_hit ? (sum_q - TSUM_W'(req_q)) : sum_q;
  assign total_sat  = (total_true > TSUM_W'(SUM_MAX)) ? SUM_MAX : 20'(total_true);

  // hole memory, write port shared by load and write-back
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [SIZE_BITS-1:0] mem_rdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = IDX_W'(hole_slot_i);
    mem_wdata = SIZE_BITS'(size_value_i);
    if (accept && (mode_i == MODE_LOAD) && slot_ok) begin
      mem_we = 1'b1;
    end else if ((state_q == ST_FINISH) && alloc_hit) begin
      mem_we    = 1'b1;
      mem_waddr = pos_q;
      mem_wdata = new_val;
    end
  end

  fpha_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_HOLES)
  ) u_hole_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issuing),
    .raddr_i (rd_addr_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  // hole read back, never written holes read as zero
  logic [SIZE_BITS-1:0] hole_val;
  logic [CMP_W-1:0]     hole_cmp;
  logic [CMP_W-1:0]     best_cmp;
  logic [CMP_W-1:0]     req_cmp;
  logic                 fits;
  logic                 take;

  assign hole_val = valid_q[pend_idx_q] ? mem_rdata : '0;
  assign hole_cmp = CMP_W'(hole_val);
  assign best_cmp = CMP_W'(best_q);
  assign req_cmp  = CMP_W'(req_q);
  assign fits     = (hole_cmp >= req_cmp);

  always_comb begin
    take = 1'b0;
    if (pend_q && fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else begin
        case (fit_policy_q)
          POL_BEST:  take = (hole_cmp < best_cmp);
          POL_WORST: take = (hole_cmp > best_cmp);
          default:   take = 1'b0;
        endcase
      end
    end
  end

  // state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    busy    = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // last read consumed, nothing in flight
        if (!issuing && !pend_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      pend_q    <= 1'b0;
      rd_addr_q <= '0;
      found_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
      end
      pend_q <= issuing;
      done_q <= (state_q == ST_FINISH);
      if (accept) begin
        rd_addr_q <= '0;
        found_q   <= 1'b0;
      end else begin
        if (issuing) begin
          rd_addr_q <= rd_addr_q + CNT_W'(1);
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // datapath flops
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= mode_i;
      slot_q    <= hole_slot_i;
      req_q     <= size_value_i;
      slot_ok_q <= slot_ok;
      sum_q     <= '0;
    end else if (pend_q) begin
      sum_q <= sum_q + TSUM_W'(hole_val);
    end
    if (issuing) begin
      pend_idx_q <= rd_addr_q[IDX_W-1:0];
    end
    if (take) begin
      pos_q  <= pend_idx_q;
      best_q <= hole_val;
    end
    if (state_q == ST_FINISH) begin
      granted_q <= alloc_hit || load_ok;
      total_q   <= total_sat;
      if (alloc_hit) begin
        chosen_q <= 4'(pos_q);
        remain_q <= 16'(new_val);
      end else if (load_ok) begin
        chosen_q <= slot_q;
        remain_q <= 16'(load_val);
      end else begin
        chosen_q <= '0;
        remain_q <= '0;
      end
    end
  end

  assign done_o           = done_q;
  assign granted_o        = granted_q;
  assign chosen_hole_o    = chosen_q;
  assign hole_remaining_o = remain_q;
  assign total_free_o     = total_q;

  // checks
  `FPHA_ASSERT_NXT(a_finish_strobe, state_q == ST_FINISH, done_q, "result strobe missing")
  `FPHA_ASSERT_IMP(a_pend_in_scan, pend_q, state_q == ST_SCAN, "read data outside scan")
  `FPHA_ASSERT_IMP(a_reject_zero, done_q && !granted_q, (chosen_q == '0) && (remain_q == '0),
                   "rejected request reports a hole")
  `FPHA_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done_q, "request not held busy")

endmodule

// File: sv/fpha_ram.sv
// ---------------------------------------------------------------------------
// fpha_ram
// generic one write port, one read port ram with registered read data
// ---------------------------------------------------------------------------
module fpha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
